FILE: rtl/slis_pkg.sv
// Package for the sorted list intersection seek block: sizes, codes, structs.
// Used by slis_cell and the top level; depends on nothing.
`default_nettype none
package slis_pkg;

  localparam int MAX_LISTS  = 8;
  localparam int LIST_DEPTH = 1024;
  localparam int VALUE_BITS = 32;

  localparam int PTR_W = $clog2(LIST_DEPTH);
  localparam int LEN_W = $clog2(LIST_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_LISTS + 1);
  localparam int ID_W  = 3;
  localparam int CFG_W = 4;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_SEEK   = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_REWIND
  } cmd_e;

  typedef enum logic {
    TOK_MAX,
    TOK_LEAP
  } tok_kind_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic                  sel;
    logic                  in_use;
    logic [VALUE_BITS-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic                  valid;
    tok_kind_e             kind;
    logic                  fail;
    logic                  agreed;
    logic [VALUE_BITS-1:0] value;
  } tok_t;

endpackage
`default_nettype wire

FILE: rtl/slis_in_if.sv
// Input channel of the seek block: valid/ready plus command payload.
// Depends on nothing.
`default_nettype none
interface slis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  list_id;
  logic [31:0] operand_value;

  modport source (output valid, mode, list_id, operand_value, input ready);
  modport sink   (input valid, mode, list_id, operand_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/slis_out_if.sv
// Result channel of the seek block: valid/ready plus found flag and value.
// Depends on nothing.
`default_nettype none
interface slis_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] common_value;

  modport source (output valid, found, common_value, input ready);
  modport sink   (input valid, found, common_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/slis_cell.sv
// One list cell: list memory, length, cursor and head, plus a token stage.
// Depends on slis_pkg.
`default_nettype none
module slis_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire slis_pkg::cell_ctl_t ctl_i,
  input  wire slis_pkg::tok_t     tok_i,
  output slis_pkg::tok_t          tok_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_CHECK = 3'b010,
    C_WAIT  = 3'b100
  } cstate_e;

  logic [slis_pkg::VALUE_BITS-1:0] mem [slis_pkg::LIST_DEPTH];
  logic [slis_pkg::VALUE_BITS-1:0] rd_q, head_q, head_d;
  logic [slis_pkg::LEN_W-1:0]      len_q, len_d;
  logic [slis_pkg::PTR_W-1:0]      cur_q, cur_d, rd_addr;
  logic [slis_pkg::LEN_W-1:0]      cur_next;
  cstate_e                         st_q, st_d;
  slis_pkg::tok_t                  tq_q, tq_d, to_d;
  logic                            pend_q, pend_d, wr_en;

  assign cur_next = slis_pkg::LEN_W'(cur_q) + slis_pkg::LEN_W'(1);
  assign wr_en = (ctl_i.cmd == slis_pkg::CMD_APPEND) && ctl_i.sel &&
                 (len_q < slis_pkg::LEN_W'(slis_pkg::LIST_DEPTH));

  always_comb begin
    len_d   = len_q;
    cur_d   = cur_q;
    head_d  = head_q;
    st_d    = st_q;
    tq_d    = tq_q;
    to_d    = tq_q;
    to_d.valid = 1'b0;
    pend_d  = 1'b0;
    rd_addr = cur_q;

    unique case (ctl_i.cmd)
      slis_pkg::CMD_CLEAR: begin
        len_d = '0;
        cur_d = '0;
      end
      slis_pkg::CMD_APPEND: begin
        if (wr_en) begin
          len_d = len_q + slis_pkg::LEN_W'(1);
          if (len_q == '0) begin
            cur_d  = '0;
            head_d = ctl_i.value;
          end
        end
      end
      slis_pkg::CMD_REWIND: begin
        cur_d   = '0;
        rd_addr = '0;
        pend_d  = 1'b1;
      end
      default: ;
    endcase

    // load the head from the rewind read
    if (pend_q && (len_q != '0)) head_d = rd_q;

    unique case (st_q)
      C_IDLE: begin
        if (tok_i.valid) begin
          tq_d = tok_i;
          st_d = C_CHECK;
        end
      end
      C_CHECK: begin
        if (tq_q.fail || !ctl_i.in_use) begin
          to_d.valid = 1'b1;
          st_d = C_IDLE;
        end else if (len_q == '0) begin
          to_d.valid = 1'b1;
          to_d.fail  = 1'b1;
          st_d = C_IDLE;
        end else if (tq_q.kind == slis_pkg::TOK_MAX) begin
          to_d.valid = 1'b1;
          if (head_q > tq_q.value) to_d.value = head_q;
          st_d = C_IDLE;
        end else if (head_q < tq_q.value) begin
          if (cur_next >= len_q) begin
            to_d.valid = 1'b1;
            to_d.fail  = 1'b1;
            st_d = C_IDLE;
          end else begin
            // advance one element and fetch it
            cur_d   = cur_next[slis_pkg::PTR_W-1:0];
            rd_addr = cur_next[slis_pkg::PTR_W-1:0];
            st_d    = C_WAIT;
          end
        end else begin
          to_d.valid = 1'b1;
          if (tq_q.value < head_q) begin
            to_d.agreed = 1'b0;
            to_d.value  = head_q;
          end
          st_d = C_IDLE;
        end
      end
      C_WAIT: begin
        head_d = rd_q;
        st_d   = C_CHECK;
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[len_q[slis_pkg::PTR_W-1:0]] <= ctl_i.value;
    rd_q   <= mem[rd_addr];
    head_q <= head_d;
    tq_q   <= tq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cur_q  <= '0;
      st_q   <= C_IDLE;
      pend_q <= 1'b0;
      tok_o  <= '0;
    end else begin
      len_q  <= len_d;
      cur_q  <= cur_d;
      st_q   <= st_d;
      pend_q <= pend_d;
      tok_o  <= to_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sorted_list_intersection_seek.sv
// Top level of the sorted list intersection seek block: sequencer, cell row,
// result register. Depends on slis_pkg, slis_in_if, slis_out_if, slis_cell.
//
//  channel | dir | beat contents                       | when
//  in_i    | in  | mode, list_id, operand_value        | valid && ready
//  out_o   | out | found, common_value                 | valid && ready
//  cfg     | in  | lists_in_use (4 bits)               | cfg_we_i high
//
// Clear and append act on the cells straight from the idle state. Start goes
// through the rewind state, then a max pass and at least one leap pass of the
// token. Each pass runs through the idle and check states of every cell and
// back for re-injection, and each cursor step inside a cell adds a wait state
// for its registered list memory; a seek that moves takes at least one pass.
// The result is then loaded from the done state into the output register.
// Reset empties every list and ends any search; no clearing pass is needed.
// A waiting result sits in the output register; the block takes the next
// beat meanwhile, and holds a new result back only while that register is full and out_o is not ready.
`default_nettype none
module sorted_list_intersection_seek (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [slis_pkg::CFG_W-1:0] cfg_wdata_i,
  slis_in_if.sink                         in_i,
  slis_out_if.source                      out_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REW  = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                           state_q, state_d;
  logic [slis_pkg::CFG_W-1:0]       lists_q;
  logic [slis_pkg::CNT_W-1:0]       n_act, lists_w;
  logic                             live_q, live_d;
  logic [slis_pkg::VALUE_BITS-1:0]  cc_q, cc_d, val;
  logic                             rf_q, rf_d;
  logic [slis_pkg::VALUE_BITS-1:0]  rv_q, rv_d;
  logic                             ov_q, of_q;
  logic [31:0]                      oval_q;
  logic                             accept, load;
  slis_pkg::tok_t                   inj_d, inj_q;
  slis_pkg::tok_t                   chain [slis_pkg::MAX_LISTS+1];
  slis_pkg::cell_ctl_t              ctl [slis_pkg::MAX_LISTS];
  slis_pkg::cmd_e                   cmd;
  logic [slis_pkg::MAX_LISTS:0]     tok_v;

  assign val    = in_i.operand_value[slis_pkg::VALUE_BITS-1:0];
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign load   = (state_q == S_DONE) && (!ov_q || out_o.ready);

  // clamp the list count to 1..MAX_LISTS
  assign lists_w = slis_pkg::CNT_W'(lists_q);
  always_comb begin
    priority if (lists_w == '0) n_act = slis_pkg::CNT_W'(1);
    else if (lists_w > slis_pkg::CNT_W'(slis_pkg::MAX_LISTS))
      n_act = slis_pkg::CNT_W'(slis_pkg::MAX_LISTS);
    else n_act = lists_w;
  end

  always_comb begin
    state_d = state_q;
    live_d  = live_q;
    cc_d    = cc_q;
    rf_d    = rf_q;
    rv_d    = rv_q;
    inj_d   = '0;
    cmd     = slis_pkg::CMD_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.mode)
            slis_pkg::MODE_CLEAR: begin
              cmd    = slis_pkg::CMD_CLEAR;
              live_d = 1'b0;
              cc_d   = '0;
            end
            slis_pkg::MODE_APPEND: cmd = slis_pkg::CMD_APPEND;
            slis_pkg::MODE_START: begin
              cmd     = slis_pkg::CMD_REWIND;
              state_d = S_REW;
            end
            slis_pkg::MODE_SEEK: begin
              if (!live_q || (val == cc_q)) begin
                // no search, or same target: answer at once
                rf_d    = live_q;
                rv_d    = live_q ? cc_q : '0;
                state_d = S_DONE;
              end else begin
                inj_d.valid  = 1'b1;
                inj_d.kind   = slis_pkg::TOK_LEAP;
                inj_d.agreed = 1'b1;
                inj_d.value  = val;
                state_d      = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_REW: begin
        // heads take entry zero at this edge, before the token arrives: gather the largest head
        inj_d.valid  = 1'b1;
        inj_d.kind   = slis_pkg::TOK_MAX;
        inj_d.agreed = 1'b1;
        state_d      = S_RUN;
      end
      S_RUN: begin
        if (chain[slis_pkg::MAX_LISTS].valid) begin
          if (chain[slis_pkg::MAX_LISTS].fail) begin
            rf_d    = 1'b0;
            rv_d    = '0;
            live_d  = 1'b0;
            state_d = S_DONE;
          end else if (chain[slis_pkg::MAX_LISTS].kind == slis_pkg::TOK_LEAP &&
                       chain[slis_pkg::MAX_LISTS].agreed) begin
            rf_d    = 1'b1;
            rv_d    = chain[slis_pkg::MAX_LISTS].value;
            cc_d    = chain[slis_pkg::MAX_LISTS].value;
            live_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            // send the candidate round the row again
            inj_d.valid  = 1'b1;
            inj_d.kind   = slis_pkg::TOK_LEAP;
            inj_d.agreed = 1'b1;
            inj_d.value  = chain[slis_pkg::MAX_LISTS].value;
          end
        end
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign chain[0] = inj_q;

  for (genvar i = 0; i < slis_pkg::MAX_LISTS; i++) begin : g_cell
    assign ctl[i].cmd    = cmd;
    assign ctl[i].sel    = (in_i.list_id == slis_pkg::ID_W'(i));
    assign ctl[i].in_use = (slis_pkg::CNT_W'(i) < n_act);
    assign ctl[i].value  = val;
    assign tok_v[i]      = chain[i].valid;

    slis_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[i]),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end
  assign tok_v[slis_pkg::MAX_LISTS] = chain[slis_pkg::MAX_LISTS].valid;

  always_ff @(posedge clk_i) begin
    cc_q <= cc_d;
    rv_q <= rv_d;
    rf_q <= rf_d;
    if (load) begin
      of_q   <= rf_q;
      oval_q <= 32'(rv_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lists_q <= slis_pkg::CFG_W'(1);
      live_q  <= 1'b0;
      ov_q    <= 1'b0;
      inj_q   <= '0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      inj_q   <= inj_d;
      if (cfg_we_i) lists_q <= cfg_wdata_i;
      if (load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.found        = of_q;
  assign out_o.common_value = oval_q;

  // only one token walks the row at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_v)) else $error("more than one token in the cell row");

  a_ret_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[slis_pkg::MAX_LISTS].valid |-> state_q == S_RUN)
    else $error("token returned outside a search");

  a_dead_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.mode == slis_pkg::MODE_SEEK && !live_q |=> state_q == S_DONE && !rf_q)
    else $error("seek without live search did not answer at once");

endmodule
`default_nettype wire
